[hw/rtl/sli_pkg.sv]
`timescale 1ns / 1ps

package sli_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int STATUS_W = 3;
    localparam int OP_W = 2;
    localparam int OUT_W = STATUS_W + VALUE_W + COUNT_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUMP     = 3'd5;

    // flips signed order into unsigned order
    localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;

    typedef struct packed {
        logic load;        // capture the incoming item
        logic exec;        // apply insert/delete, or a single-result op, and emit
        logic dump_start;  // clear the dump index
        logic dump_emit;   // emit one dump entry and advance
    } sli_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            dump_last;
    } sli_stat_t;

endpackage

[hw/rtl/sli_ctrl.sv]
`timescale 1ns / 1ps

module sli_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_op,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  sli_pkg::sli_stat_t stat,
    output sli_pkg::sli_cmd_t  cmd
);
    import sli_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_op != OP_NONE) begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    if (stat.op == OP_DUMP && !stat.empty) begin
                        cmd.dump_start = 1'b1;
                        state_next = S_DUMP;
                    end else begin
                        cmd.exec = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DUMP: begin
                if (slot_free) begin
                    cmd.dump_emit = 1'b1;
                    if (stat.dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec || cmd.dump_emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/sli_dpath.sv]
`timescale 1ns / 1ps

module sli_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sli_pkg::sli_cmd_t       cmd,
    input  logic [1:0]              s_op,
    input  logic [31:0]             s_value,
    output sli_pkg::sli_stat_t      stat,
    output logic [39:0]             m_tdata,
    output logic                    m_tlast
);
    import sli_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [VALUE_W-1:0] entries_reg [CAPACITY];
    logic [VALUE_W-1:0] ins_next    [CAPACITY];
    logic [VALUE_W-1:0] del_next    [CAPACITY];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [OP_W-1:0]    op_reg;
    logic [VALUE_W-1:0] value_reg;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  outval_reg, outval_next;
    logic [COUNT_W-1:0]  outcnt_reg, outcnt_next;
    logic                last_reg, last_next;

    logic [CAPACITY-1:0] le, eq, seen;
    logic                full, empty, found;
    logic                do_ins, do_del;

    assign full  = (count_reg >= CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);
    assign found = seen[CAPACITY-1];

    // per-cell compare against the held value; cells past the count never match
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            le[i] = (CNT_W'(i) < count_reg) &&
                    ((entries_reg[i] ^ SIGN_FLIP) <= (value_reg ^ SIGN_FLIP));
            eq[i] = (CNT_W'(i) < count_reg) && (entries_reg[i] == value_reg);
        end
    end

    // first-match mask for delete
    always_comb begin
        seen[0] = eq[0];
        for (int i = 1; i < CAPACITY; i++) begin
            seen[i] = seen[i-1] | eq[i];
        end
    end

    // le is a prefix: the first cell without it takes the new value,
    // cells after it take their left neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign ins_next[g] = le[g] ? entries_reg[g] : value_reg;
        end else begin : g_rest
            assign ins_next[g] = le[g]   ? entries_reg[g] :
                                 le[g-1] ? value_reg : entries_reg[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign del_next[g] = entries_reg[g];
        end else begin : g_mid
            assign del_next[g] = seen[g] ? entries_reg[g+1] : entries_reg[g];
        end
    end

    assign do_ins = cmd.exec && (op_reg == OP_INSERT) && !full;
    assign do_del = cmd.exec && (op_reg == OP_DELETE) && found;

    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // result payload
    always_comb begin
        status_next = status_reg;
        outval_next = outval_reg;
        outcnt_next = outcnt_reg;
        last_next   = last_reg;
        if (cmd.dump_emit) begin
            status_next = ST_DUMP;
            outval_next = entries_reg[idx_reg];
            outcnt_next = COUNT_W'(count_reg);
            last_next   = stat.dump_last;
        end else if (cmd.exec) begin
            outval_next = '0;
            last_next   = 1'b1;
            outcnt_next = COUNT_W'(count_next);
            priority if (op_reg == OP_INSERT) begin
                status_next = full ? ST_FULL : ST_INSERTED;
            end else if (empty) begin
                status_next = ST_EMPTY;
            end else if (op_reg == OP_DELETE) begin
                status_next = found ? ST_DELETED : ST_NOTFOUND;
            end else begin
                status_next = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.dump_start) begin
                idx_reg <= '0;
            end else if (cmd.dump_emit) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_op;
            value_reg <= s_value;
        end
        if (do_ins) begin
            entries_reg <= ins_next;
        end else if (do_del) begin
            entries_reg <= del_next;
        end
        status_reg <= status_next;
        outval_reg <= outval_next;
        outcnt_reg <= outcnt_next;
        last_reg   <= last_next;
    end

    assign stat.op        = op_reg;
    assign stat.empty     = empty;
    assign stat.dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign m_tdata = {outcnt_reg, outval_reg, status_reg};
    assign m_tlast = last_reg;

endmodule

[hw/rtl/sorted_list_insert_delete.sv]
// An item is taken only in S_IDLE, which registers its op and value; in S_EXEC its result
// is registered and m_tvalid raised once the output is free. A dump of a non-empty list
// goes on from S_EXEC to S_DUMP and registers its first entry there.
// The block takes no new item until it is through with the last one; a dump emits its
// entries one entry per cycle while the output is free, from the shared entry register file.
// Reset (aresetn low, synchronous) empties the list and clears all handshake state;
// the entry registers themselves are not cleared.
`timescale 1ns / 1ps

module sorted_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] status, [34:3] entry_value, [39:35] entry_count
    output logic        m_tlast
);
    import sli_pkg::*;

    sli_cmd_t  cmd;
    sli_stat_t stat;

    sli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sli_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_op     (s_tuser),
        .s_value  (s_tdata),
        .stat     (stat),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.exec, cmd.dump_start, cmd.dump_emit}))
        else $error("controller issued overlapping commands");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec || cmd.dump_emit) |=> m_tvalid)
        else $error("emitted result not presented");

    a_dump_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dump_emit |-> !stat.empty)
        else $error("dump entry emitted from empty list");

    a_dump_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.dump_emit && stat.dump_last) |=> !cmd.dump_emit)
        else $error("dump ran past the last entry");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import sli_pkg::*;

    localparam int LIST_CAP    = 16;
    localparam int RANDOM_OPS  = 310;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } list_op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  entry_value;
        logic [COUNT_W-1:0]  entry_count;
        logic                last;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // [31:0] value
    logic [1:0]  s_tuser = '0;    // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [2:0] status, [34:3] entry_value, [39:35] entry_count
    logic        m_tlast;

    list_op_t     pending_ops[$];
    list_result_t expected_results[$];

    // shadow copy of the sorted list
    logic signed [VALUE_W-1:0] shadow_vals [LIST_CAP];
    int                        shadow_len = 0;

    logic [VALUE_W-1:0] value_pool [8];

    int mismatches = 0;
    int ops_sent   = 0;
    int send_gap   = 0;
    int ready_gap  = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int results_taken = 0;
    int idle_cycles   = 0;
    bit watch_on      = 1'b0;

    sorted_list_insert_delete #(.CAPACITY(LIST_CAP)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic void push_result(input logic [STATUS_W-1:0] status,
                                        input logic [VALUE_W-1:0] val,
                                        input int count, input logic last);
        list_result_t r;
        r.status      = status;
        r.entry_value = val;
        r.entry_count = count[COUNT_W-1:0];
        r.last        = last;
        expected_results.push_back(r);
    endfunction

    // updates the shadow list and queues the results the item should produce
    function automatic void predict_list_op(input logic [OP_W-1:0] op,
                                            input logic [VALUE_W-1:0] value);
        logic signed [VALUE_W-1:0] sval;
        int pos;
        sval = value;
        pos = 0;
        case (op)
            OP_INSERT: begin
                if (shadow_len >= LIST_CAP) begin
                    push_result(ST_FULL, '0, shadow_len, 1'b1);
                end else begin
                    // equal values already stored stay ahead of the new one
                    while (pos < shadow_len && shadow_vals[pos] <= sval)
                        pos++;
                    for (int i = shadow_len; i > pos; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[pos] = sval;
                    shadow_len++;
                    push_result(ST_INSERTED, '0, shadow_len, 1'b1);
                end
            end
            OP_DELETE: begin
                if (shadow_len == 0) begin
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    while (pos < shadow_len && shadow_vals[pos] != sval)
                        pos++;
                    if (pos >= shadow_len) begin
                        push_result(ST_NOTFOUND, '0, shadow_len, 1'b1);
                    end else begin
                        for (int i = pos; i + 1 < shadow_len; i++)
                            shadow_vals[i] = shadow_vals[i+1];
                        shadow_len--;
                        push_result(ST_DELETED, '0, shadow_len, 1'b1);
                    end
                end
            end
            OP_DUMP: begin
                if (shadow_len == 0) begin
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_len; i++)
                        push_result(ST_DUMP, shadow_vals[i], shadow_len,
                                    (i + 1 == shadow_len));
                end
            end
            default: ;  // unused op code: no result
        endcase
    endfunction

    always @(posedge aclk) begin : drive_ops
        list_op_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_list_op(s_tuser, s_tdata);
                ops_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    nxt = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tuser  <= nxt.op;
                    send_gap <= pick_gap((ops_sent / 40) % 4 == 1);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : drive_ready
        int g;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            ready_gap <= 0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready)
                results_taken++;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && results_taken >= 60) begin
                // long hold-off so the list backs up and s_tready drops
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap <= ready_gap - 1;
                m_tready  <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                g = pick_gap((results_taken / 50) % 4 == 2);
                if (g > 0) begin
                    m_tready  <= 1'b0;
                    ready_gap <= g - 1;
                end else begin
                    m_tready <= 1'b1;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        list_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: status %0d value %h count %0d last %b",
                             m_tdata[2:0], m_tdata[34:3], m_tdata[39:35], m_tlast);
                mismatches++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[2:0] !== exp_r.status || m_tdata[34:3] !== exp_r.entry_value ||
                    m_tdata[39:35] !== exp_r.entry_count || m_tlast !== exp_r.last) begin
                    if (mismatches < 10)
                        $display("mismatch: exp %0d %h %0d %b, got %0d %h %0d %b",
                                 exp_r.status, exp_r.entry_value, exp_r.entry_count,
                                 exp_r.last, m_tdata[2:0], m_tdata[34:3],
                                 m_tdata[39:35], m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (watch_on) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT) begin
                $display("** sorted_list_insert_delete: FAILED **");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        list_op_t it;
        it.op    = op;
        it.value = value;
        pending_ops.push_back(it);
    endtask

    initial begin : stimulus
        int made;
        int seg_kind;
        int seg_len;
        int ins_pct;
        int r;
        made = 0;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        // directed: empty cases, extremes, duplicates, misses, emptying the list
        add_op(OP_DUMP,   32'h1234_5678);
        add_op(OP_DELETE, 32'h0000_0005);
        add_op(OP_NONE,   32'hffff_ffff);
        add_op(OP_INSERT, 32'h7fff_ffff);
        add_op(OP_INSERT, 32'h8000_0000);
        add_op(OP_INSERT, 32'h0000_0000);
        add_op(OP_INSERT, 32'hffff_ffff);
        add_op(OP_INSERT, 32'h0000_0000);
        add_op(OP_DUMP,   32'h0000_0000);
        add_op(OP_DELETE, 32'h0000_0001);
        add_op(OP_DELETE, 32'h0000_0000);
        add_op(OP_DELETE, 32'h7fff_ffff);
        add_op(OP_DELETE, 32'h8000_0000);
        add_op(OP_DELETE, 32'hffff_ffff);
        add_op(OP_DUMP,   32'haaaa_aaaa);
        add_op(OP_DELETE, 32'h0000_0000);
        add_op(OP_DUMP,   32'h5555_5555);

        // random: fill, drain and mixed runs so full and empty are both reached
        while (made < RANDOM_OPS) begin
            seg_kind = $urandom_range(0, 2);
            seg_len  = $urandom_range(20, 40);
            ins_pct  = (seg_kind == 0) ? 80 : (seg_kind == 1) ? 15 : 50;
            for (int k = 0; k < seg_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    add_op(OP_NONE, $urandom);
                end else begin
                    if (r < 13)
                        add_op(OP_DUMP, $urandom);
                    else if ($urandom_range(0, 99) < ins_pct)
                        add_op(OP_INSERT, pick_value(40));
                    else
                        add_op(OP_DELETE, pick_value(70));
                    made++;
                end
            end
        end

        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        watch_on <= 1'b1;

        do
            @(negedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
        watch_on = 1'b0;

        if (mismatches == 0 && expected_results.size() == 0)
            $display("** sorted_list_insert_delete: PASSED **");
        else
            $display("** sorted_list_insert_delete: FAILED **");
        $finish;
    end

endmodule
